/* hw/rtl/qadm_pkg.sv */
// shared constants and types of the bounded queue admission timer
package qadm_pkg;

  // ring of pending finish times
  localparam int RING_DEPTH = 256;
  localparam int PTR_BITS   = $clog2(RING_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;

  // field widths
  localparam int TIME_BITS  = 40;
  localparam int ARR_BITS   = 30;
  localparam int SVC_BITS   = 30;
  localparam int LIMIT_BITS = 8;
  localparam int CMP_BITS   = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd255;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_ADMIT
  } qadm_state_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                 valid;
    logic                 accepted;
    logic [TIME_BITS-1:0] finish;
  } qadm_res_t;

  // ring memory access for one cycle
  typedef struct packed {
    logic                 we;
    logic [PTR_BITS-1:0]  waddr;
    logic [TIME_BITS-1:0] wdata;
    logic [PTR_BITS-1:0]  raddr;
  } qadm_ram_req_t;

  // status seen by the top level checks
  typedef struct packed {
    logic [CNT_BITS-1:0]  count;
    logic [TIME_BITS-1:0] last_finish;
  } qadm_stat_t;

endpackage

/* hw/rtl/qadm_if.sv */
// valid/ready channels for requests and results

interface qadm_req_if;
  import qadm_pkg::*;
  logic                valid;
  logic                ready;
  logic [ARR_BITS-1:0] arrival_time;
  logic [SVC_BITS-1:0] service_time;

  modport source (output valid, output arrival_time, output service_time, input ready);
  modport sink   (input valid, input arrival_time, input service_time, output ready);
endinterface

interface qadm_res_if;
  import qadm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [TIME_BITS-1:0] finish_time;

  modport source (output valid, output accepted, output finish_time, input ready);
  modport sink   (input valid, input accepted, input finish_time, output ready);
endinterface

/* hw/rtl/qadm_ring_ram.sv */
// generic single write port, single read port ram with registered read data
module qadm_ring_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/qadm_ctrl.sv */
// sequencer: retires expired finish times and admits or rejects each request
module qadm_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  qadm_req_if.sink                             in_ch,
  input  logic                                 cfg_we,
  input  logic [qadm_pkg::LIMIT_BITS-1:0]      cfg_wdata,
  input  logic                                 slot_free,
  input  logic [qadm_pkg::TIME_BITS-1:0]       rd_data,
  output qadm_pkg::qadm_ram_req_t              ram_req,
  output qadm_pkg::qadm_res_t                  res,
  output qadm_pkg::qadm_stat_t                 stat
);
  import qadm_pkg::*;

  qadm_state_t           state_r, state_nxt;
  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;
  logic [LIMIT_BITS-1:0] limit_r;
  logic [ARR_BITS-1:0]   arr_r, arr_nxt;
  logic [SVC_BITS-1:0]   svc_r, svc_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [TIME_BITS-1:0]  fwd_data_r, fwd_data_nxt;

  logic [TIME_BITS-1:0]  head_val;
  logic [TIME_BITS-1:0]  arr_ext;
  logic                  pop_hit;
  logic                  admit;
  logic [PTR_BITS-1:0]   tail;
  logic [TIME_BITS-1:0]  start;
  logic [TIME_BITS:0]    sum;
  logic [TIME_BITS-1:0]  fin;

  // head entry, with the write of the previous cycle bypassed in
  assign head_val = fwd_r ? fwd_data_r : rd_data;
  assign arr_ext  = TIME_BITS'(arr_r);
  assign pop_hit  = (count_r != '0) && (head_val <= arr_ext);

  // admission check and saturating finish time
  assign admit = (CMP_BITS'(count_r) <= CMP_BITS'(limit_r))
              && (count_r < CNT_BITS'(RING_DEPTH));
  assign tail  = head_r + count_r[PTR_BITS-1:0];
  assign start = (last_r > arr_ext) ? last_r : arr_ext;
  assign sum   = {1'b0, start} + (TIME_BITS+1)'(svc_r);
  assign fin   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_POP;
      end
      ST_POP: begin
        if (!pop_hit) state_nxt = ST_ADMIT;
      end
      ST_ADMIT: begin
        if (slot_free) state_nxt = in_ch.valid ? ST_POP : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    arr_nxt       = arr_r;
    svc_nxt       = svc_r;
    fwd_nxt       = 1'b0;
    fwd_data_nxt  = fwd_data_r;
    in_ch.ready   = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = tail;
    ram_req.wdata = fin;
    ram_req.raddr = head_r;
    res.valid     = 1'b0;
    res.accepted  = 1'b0;
    res.finish    = '0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          arr_nxt = in_ch.arrival_time;
          svc_nxt = in_ch.service_time;
        end
      end
      ST_POP: begin
        if (pop_hit) begin
          head_nxt      = head_r + 1'b1;
          count_nxt     = count_r - 1'b1;
          ram_req.raddr = head_r + 1'b1;
        end
      end
      ST_ADMIT: begin
        if (slot_free) begin
          res.valid    = 1'b1;
          res.accepted = admit;
          res.finish   = admit ? fin : '0;
          if (admit) begin
            ram_req.we = 1'b1;
            last_nxt   = fin;
            count_nxt  = count_r + 1'b1;
          end
          // take the next request right away
          in_ch.ready = 1'b1;
          if (in_ch.valid) begin
            arr_nxt      = in_ch.arrival_time;
            svc_nxt      = in_ch.service_time;
            fwd_nxt      = admit && (tail == head_r);
            fwd_data_nxt = fin;
          end
        end
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
      limit_r <= LIMIT_RESET;
      fwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      fwd_r   <= fwd_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  // request payload and bypass data
  always_ff @(posedge clk) begin
    arr_r      <= arr_nxt;
    svc_r      <= svc_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  assign stat.count       = count_r;
  assign stat.last_finish = last_r;

endmodule

/* hw/rtl/bounded_queue_admission_timer_top.sv */
// top level of the bounded queue admission timer
//
// Admission control for one server with a bounded waiting line.
// in_ch carries requests (arrival_time, service_time); a request is taken
// at a clock edge with valid and ready high. out_ch returns one result per
// request, in order: accepted and finish_time (zero when rejected).
// cfg_we / cfg_wdata write waiting_limit; write it only while no request
// is in flight.
// Pending finish times sit in a 256 x 40 ring ram with registered read
// data. After a request is taken, the sequencer retires each expired
// pending entry in turn, then a compare finds the head entry unexpired
// and the admit step accepts or rejects; the next request is taken in
// the admit step of the current one. The result is registered in the
// output register and shows on out_ch from there.
// Reset empties the ring, clears the last finish time and sets
// waiting_limit to 255; no clearing pass is needed.
// While out_ch stalls, one result waits in the output register and the
// next request is worked up to its admit step, where it holds.
module bounded_queue_admission_timer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  qadm_req_if.sink                         in_ch,
  qadm_res_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [qadm_pkg::LIMIT_BITS-1:0]  cfg_wdata
);
  import qadm_pkg::*;

  qadm_ram_req_t        ram_req;
  qadm_res_t            res;
  qadm_stat_t           stat;
  logic [TIME_BITS-1:0] rd_data;
  logic                 slot_free;

  logic                 out_valid_r;
  logic                 out_accepted_r;
  logic [TIME_BITS-1:0] out_finish_r;

  // ring of pending finish times
  qadm_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (TIME_BITS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // retire and admit sequencer
  qadm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .slot_free (slot_free),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res       (res),
    .stat      (stat)
  );

  // output register
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_accepted_r <= res.accepted;
      out_finish_r   <= res.finish;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_accepted_r;
  assign out_ch.finish_time = out_finish_r;

`ifndef SYNTH
  // a result is only loaded when the held one is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over an unsent result");

  // an admitted finish time becomes the last finish time
  a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.accepted) |=> (stat.last_finish == $past(res.finish)))
    else $error("last finish time not updated on admit");

  // pending count never exceeds the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_BITS'(RING_DEPTH))
    else $error("ring count exceeds ring depth");
`endif

endmodule
